[design/range_payload_pattern_checker_top_defines.svh]
// assertion macros shared by the range payload pattern checker modules
`ifndef RANGE_PAYLOAD_PATTERN_CHECKER_TOP_DEFINES_SVH
`define RANGE_PAYLOAD_PATTERN_CHECKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define RPPC_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("rppc assertion failed");
// condition must never be true outside reset
`define RPPC_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("rppc forbidden condition seen");
`else
`define RPPC_ASSERT(name, clk, rstn, prop)
`define RPPC_ASSERT_NEVER(name, clk, rstn, cond)
`endif

`endif

[design/rppc_pkg.sv]
// types, constants and codes of the range payload pattern checker
package rppc_pkg;

  // field and register widths
  localparam int OffW  = 26;
  localparam int LenW  = 27;
  localparam int CntW  = 27;
  localparam int PosW  = 28;
  localparam int DataW = 8;

  // largest object size, default of the top level parameter
  localparam int MaxObjectBytesDefault = 67108864;

  // splitmix64 finalizer constants
  localparam logic [63:0] HashGolden = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] HashMul1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] HashMul2   = 64'h94d049bb133111eb;
  localparam int          HashShift1 = 30;
  localparam int          HashShift2 = 27;
  localparam int          HashShift3 = 31;

  // result codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_MANY = 2'd1,
    STATUS_TOO_FEW  = 2'd2,
    STATUS_MISMATCH = 2'd3
  } status_e;

  // register indexes
  typedef enum logic {
    REG_START_OFFSET    = 1'b0,
    REG_EXPECTED_LENGTH = 1'b1
  } reg_idx_e;

  // partial product selects of the shared multiplier
  typedef enum logic [1:0] {
    MUL_LL = 2'd0,
    MUL_LH = 2'd1,
    MUL_HL = 2'd2
  } mul_step_e;

  // input word
  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic             last;
  } in_word_t;

  // output word
  typedef struct packed {
    status_e         status;
    logic [CntW-1:0] bytes_received;
  } out_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic      load;
    logic      mix;
    logic      round;
    logic      mul_en;
    mul_step_e mul_step;
    logic      check;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;
    logic out_busy;
  } dp_stat_t;

endpackage

[design/rppc_regs.sv]
// apb configuration registers: start offset and expected length
module rppc_regs import rppc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output logic [OffW-1:0] start_offset_o,
  output logic [LenW-1:0] expected_length_o
);

  logic [OffW-1:0] start_offset_q;
  logic [LenW-1:0] expected_length_q;
  reg_idx_e        idx;
  logic            wr_en;

  assign idx   = reg_idx_e'(paddr[2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_offset_q    <= '0;
      expected_length_q <= LenW'(1);
    end else if (wr_en) begin
      case (idx)
        REG_START_OFFSET:    start_offset_q    <= pwdata[OffW-1:0];
        REG_EXPECTED_LENGTH: expected_length_q <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_START_OFFSET:    prdata = 32'(start_offset_q);
      REG_EXPECTED_LENGTH: prdata = 32'(expected_length_q);
      default:             prdata = '0;
    endcase
  end

  assign start_offset_o    = start_offset_q;
  assign expected_length_o = expected_length_q;

endmodule

[design/rppc_ctrl.sv]
// sequencer for the two finalizer rounds and the per-byte check
`include "range_payload_pattern_checker_top_defines.svh"
module rppc_ctrl import rppc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_MUL_LL,
    ST_MUL_LH,
    ST_MUL_HL,
    ST_CHECK
  } state_e;

  state_e state_q;
  logic   round_q;
  logic   check_stall;

  // last byte while the result slot is still occupied by an earlier result
  assign check_stall = stat_i.last && stat_i.out_busy;

  // state and round
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      round_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_MIX;
            round_q <= 1'b0;
          end
        end
        ST_MIX:    state_q <= ST_MUL_LL;
        ST_MUL_LL: state_q <= ST_MUL_LH;
        ST_MUL_LH: state_q <= ST_MUL_HL;
        ST_MUL_HL: begin
          if (!round_q) begin
            round_q <= 1'b1;
            state_q <= ST_MIX;
          end else begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!check_stall) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.round    = round_q;
    cmd_o.mul_step = MUL_LL;
    case (state_q)
      ST_IDLE:   cmd_o.load = in_valid_i;
      ST_MIX:    cmd_o.mix = 1'b1;
      ST_MUL_LL: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MUL_LL;
      end
      ST_MUL_LH: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MUL_LH;
      end
      ST_MUL_HL: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MUL_HL;
      end
      ST_CHECK:  cmd_o.check = !check_stall;
      default: ;
    endcase
  end

  `RPPC_ASSERT(a_accept_starts_hash, clk_i, rst_ni,
               (state_q == ST_IDLE && in_valid_i) |=> (state_q == ST_MIX && !round_q))
  `RPPC_ASSERT(a_second_round_follows, clk_i, rst_ni,
               (state_q == ST_MUL_HL && !round_q) |=> (state_q == ST_MIX && round_q))
  `RPPC_ASSERT(a_check_waits_for_slot, clk_i, rst_ni,
               (state_q == ST_CHECK && check_stall) |=> (state_q == ST_CHECK))

endmodule

[design/rppc_dp.sv]
// datapath: pattern hash on a shared 32x32 multiplier, count, flags, result
`include "range_payload_pattern_checker_top_defines.svh"
module rppc_dp import rppc_pkg::*; #(
  parameter int MaxObjectBytes = MaxObjectBytesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dp_cmd_t         cmd_i,
  output dp_stat_t        stat_o,
  input  in_word_t        in_data_i,
  input  logic [OffW-1:0] start_offset_i,
  input  logic [LenW-1:0] expected_length_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_word_t       out_data_o
);

  localparam int MaxW = $clog2(MaxObjectBytes + 1);
  localparam int CmpW = (MaxW > LenW) ? MaxW : LenW;
  localparam logic [CntW-1:0] CntMax = '1;

  logic [DataW-1:0] data_q;
  logic             last_q;
  logic [PosW-1:0]  pos_q;
  logic [63:0]      a_q;
  logic [63:0]      acc_q;
  logic [CntW-1:0]  count_q;
  logic             mis_q;
  logic             ovf_q;
  logic             out_valid_q;
  out_word_t        out_q;

  logic [63:0]      x0;
  logic [63:0]      mix_val;
  logic [63:0]      k;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      prod;
  logic [DataW-1:0] pattern;
  logic [CmpW-1:0]  len_ext;
  logic [CmpW-1:0]  eff_len;
  logic             in_range;
  logic             too_few;
  logic [CntW-1:0]  cnt_next;
  logic             mis_next;
  logic             ovf_next;
  status_e          status;

  // mixing step of either round
  always_comb begin
    x0 = 64'(pos_q) + HashGolden;
    if (cmd_i.round) begin
      mix_val = acc_q ^ (acc_q >> HashShift2);
    end else begin
      mix_val = x0 ^ (x0 >> HashShift1);
    end
  end

  // operand select of the shared multiplier
  always_comb begin
    k     = cmd_i.round ? HashMul2 : HashMul1;
    mul_a = a_q[31:0];
    mul_b = k[31:0];
    case (cmd_i.mul_step)
      MUL_LL: begin
        mul_a = a_q[31:0];
        mul_b = k[31:0];
      end
      MUL_LH: begin
        mul_a = a_q[31:0];
        mul_b = k[63:32];
      end
      MUL_HL: begin
        mul_a = a_q[63:32];
        mul_b = k[31:0];
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // pattern byte and length checks
  always_comb begin
    pattern  = acc_q[DataW-1:0] ^ acc_q[HashShift3 +: DataW];
    len_ext  = CmpW'(expected_length_i);
    eff_len  = (len_ext > CmpW'(MaxObjectBytes)) ? CmpW'(MaxObjectBytes) : len_ext;
    in_range = CmpW'(count_q) < eff_len;
    cnt_next = (count_q == CntMax) ? count_q : count_q + CntW'(1);
    too_few  = CmpW'(cnt_next) < eff_len;
    mis_next = mis_q || (in_range && (pattern != data_q));
    ovf_next = ovf_q || !in_range;
    if (ovf_next) begin
      status = STATUS_TOO_MANY;
    end else if (too_few) begin
      status = STATUS_TOO_FEW;
    end else if (mis_next) begin
      status = STATUS_MISMATCH;
    end else begin
      status = STATUS_OK;
    end
  end

  // hash operand registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      data_q <= in_data_i.data_byte;
      last_q <= in_data_i.last;
      pos_q  <= PosW'(start_offset_i) + PosW'(count_q);
    end
    if (cmd_i.mix) begin
      a_q <= mix_val;
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_step)
        MUL_LL:  acc_q <= prod;
        default: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
      endcase
    end
  end

  // transfer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mis_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.check) begin
      if (last_q) begin
        count_q <= '0;
        mis_q   <= 1'b0;
        ovf_q   <= 1'b0;
      end else begin
        count_q <= cnt_next;
        mis_q   <= mis_next;
        ovf_q   <= ovf_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.check && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check && last_q) begin
      out_q.status         <= status;
      out_q.bytes_received <= cnt_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign stat_o.last     = last_q;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  `RPPC_ASSERT(a_last_clears_state, clk_i, rst_ni,
               (cmd_i.check && last_q) |=> (count_q == '0 && !ovf_q && !mis_q && out_valid_q))
  `RPPC_ASSERT(a_count_saturates, clk_i, rst_ni,
               (cmd_i.check && !last_q && count_q == CntMax) |=> (count_q == CntMax))
  `RPPC_ASSERT(a_overflow_latched, clk_i, rst_ni,
               (cmd_i.check && !last_q && !in_range) |=> ovf_q)
  `RPPC_ASSERT_NEVER(a_no_result_overwrite, clk_i, rst_ni,
                     cmd_i.check && last_q && out_valid_q && !out_ready_i)

endmodule

[design/range_payload_pattern_checker_top.sv]
// Range payload pattern checker. Each accepted input word is one payload byte
// with a last flag; the block compares byte i of the transfer with the low byte
// of the splitmix64 finalizer of (start_offset + i) while i is below the
// expected length (clamped to MaxObjectBytes), and on the last byte returns one
// output word: status (too many, too few, mismatch, else ok; first match wins) and
// the saturating byte count. Each byte runs in order through the accept step,
// two finalizer rounds, each a mix step plus three partial products on one
// shared 32x32 multiplier, then a check step; ready stays low from an acceptance
// until that check step is done. A last byte waits in its check step only
// while the previous output word is still untaken. Registers: start_offset at
// 0x0, expected_length at 0x4 (reset 1); write them only between bytes. No
// clearing pass follows reset.
module range_payload_pattern_checker_top import rppc_pkg::*; #(
  parameter int MaxObjectBytes = MaxObjectBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [OffW-1:0] start_offset;
  logic [LenW-1:0] expected_length;
  dp_cmd_t         cmd;
  dp_stat_t        stat;

  // configuration registers
  rppc_regs u_regs (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .start_offset_o    (start_offset),
    .expected_length_o (expected_length)
  );

  // sequencer
  rppc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // hash, compare and result datapath
  rppc_dp #(
    .MaxObjectBytes (MaxObjectBytes)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .in_data_i         (in_data_i),
    .start_offset_i    (start_offset),
    .expected_length_i (expected_length),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_data_o        (out_data_o)
  );

endmodule
